FILE: rtl/core/tpp_pkg.sv
package tpp_pkg;

    localparam int CHANNEL_BITS_DEF   = 8;
    localparam int MAX_PIXEL_BITS_DEF = 32;
    localparam int MAX_PIXEL_BITS_HI  = 32;

    // step counter width, large enough for the widest pixel plus a full row pad and a flush
    localparam int CNT_W = $clog2((MAX_PIXEL_BITS_HI + 15) / 8 + 9);

    localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;
    localparam logic [5:0]  BPP_RST        = 6'd32;
    localparam logic [6:0]  LINE_PAD_RST   = 7'd32;
    localparam logic        SWAP_RST       = 1'b0;

    localparam logic [6:0] LINE_PAD_16 = 7'd16;
    localparam logic [6:0] LINE_PAD_32 = 7'd32;
    localparam logic [6:0] LINE_PAD_64 = 7'd64;

    typedef enum logic [2:0] {
        REG_RED_MASK   = 3'd0,
        REG_GREEN_MASK = 3'd1,
        REG_BLUE_MASK  = 3'd2,
        REG_BPP        = 3'd3,
        REG_LINE_PAD   = 3'd4,
        REG_SWAP       = 3'd5
    } reg_idx_t;

    // lowest run of ones in a channel mask
    typedef struct packed {
        logic       en;
        logic [4:0] shift;
        logic [5:0] bits;
    } field_t;

    typedef struct packed {
        field_t     red;
        field_t     green;
        field_t     blue;
        logic [5:0] pw;
        logic [2:0] align;
        logic       swap;
    } cfg_t;

    typedef struct packed {
        logic row_end;
        logic img;
    } pflag_t;

    typedef struct packed {
        logic             flush;
        logic [7:0]       data;
        logic [CNT_W-1:0] remain;
        logic             img;
    } step_t;

    function automatic field_t decode_mask(input logic [31:0] m);
        field_t      f;
        logic [31:0] s;
        f.en    = |m;
        f.shift = 5'd0;
        f.bits  = 6'd32;
        for (int i = 31; i >= 0; i--) begin
            if (m[i])
            begin
                f.shift = 5'(i);
            end
        end
        s = m >> f.shift;
        for (int i = 31; i >= 0; i--) begin
            if (!s[i])
            begin
                f.bits = 6'(i);
            end
        end
        return f;
    endfunction

    function automatic logic [2:0] pad_align(input logic [6:0] v);
        logic [2:0] a;
        unique case (v)
            LINE_PAD_16: a = 3'b001;
            LINE_PAD_32: a = 3'b011;
            LINE_PAD_64: a = 3'b111;
            default:     a = 3'b000;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/tpp_cfg.sv
module tpp_cfg
    import tpp_pkg::*;
#(
    parameter int MAX_PIXEL_BITS = MAX_PIXEL_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    function automatic logic [5:0] clamp_width(input logic [5:0] v);
        logic [5:0] w;
        w = v;
        if (v == 6'd0)
        begin
            w = 6'd1;
        end
        else if (int'(v) > MAX_PIXEL_BITS)
        begin
            w = 6'(MAX_PIXEL_BITS);
        end
        return w;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // masks are decoded to shift and width as they are written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red   <= decode_mask(RED_MASK_RST);
            cfg_reg.green <= decode_mask(GREEN_MASK_RST);
            cfg_reg.blue  <= decode_mask(BLUE_MASK_RST);
            cfg_reg.pw    <= clamp_width(BPP_RST);
            cfg_reg.align <= pad_align(LINE_PAD_RST);
            cfg_reg.swap  <= SWAP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RED_MASK:   cfg_reg.red   <= decode_mask(cfg_data);
                REG_GREEN_MASK: cfg_reg.green <= decode_mask(cfg_data);
                REG_BLUE_MASK:  cfg_reg.blue  <= decode_mask(cfg_data);
                REG_BPP:        cfg_reg.pw    <= clamp_width(cfg_data[5:0]);
                REG_LINE_PAD:   cfg_reg.align <= pad_align(cfg_data[6:0]);
                REG_SWAP:       cfg_reg.swap  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

endmodule

FILE: rtl/core/tpp_place.sv
module tpp_place
    import tpp_pkg::*;
#(
    parameter int CHANNEL_BITS   = CHANNEL_BITS_DEF,
    parameter int MAX_PIXEL_BITS = MAX_PIXEL_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CHANNEL_BITS-1:0]   red,
    input  logic [CHANNEL_BITS-1:0]   green,
    input  logic [CHANNEL_BITS-1:0]   blue,
    input  pflag_t                    in_flags,
    output logic                      pix_valid,
    output logic [MAX_PIXEL_BITS-1:0] pix,
    output pflag_t                    pix_flags,
    input  logic                      pix_take
);

    logic                      pix_valid_reg;
    logic [MAX_PIXEL_BITS-1:0] pix_reg;
    pflag_t                    flags_reg;
    logic [31:0]               placed;

    function automatic logic [31:0] place(input field_t f, input logic [CHANNEL_BITS-1:0] c);
        logic [31:0] ext;
        logic [31:0] v;
        ext = 32'(c);
        if (f.bits <= 6'(CHANNEL_BITS))
        begin
            v = ext >> (6'(CHANNEL_BITS) - f.bits);
        end
        else
        begin
            v = ext << (f.bits - 6'(CHANNEL_BITS));
        end
        v = v << f.shift;
        if (!f.en)
        begin
            v = '0;
        end
        return v;
    endfunction

    assign placed    = place(cfg.red, red) | place(cfg.green, green) | place(cfg.blue, blue);
    assign in_ready  = !pix_valid_reg || pix_take;
    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;
    assign pix_flags = flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            pix_valid_reg <= 1'b1;
        end
        else if (pix_take)
        begin
            pix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pix_reg   <= placed[MAX_PIXEL_BITS-1:0];
            flags_reg <= in_flags;
        end
    end

endmodule

FILE: rtl/core/tpp_pack.sv
module tpp_pack
    import tpp_pkg::*;
#(
    parameter int MAX_PIXEL_BITS = MAX_PIXEL_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      pix_valid,
    input  logic [MAX_PIXEL_BITS-1:0] pix,
    input  pflag_t                    pix_flags,
    output logic                      pix_take,
    output logic                      step_valid,
    output step_t                     step,
    input  logic                      step_ready
);

    localparam int NBY   = (MAX_PIXEL_BITS + 15) / 8;
    localparam int AW    = 8 * NBY;
    localparam int IDX_W = $clog2(NBY);
    localparam int SH_W  = $clog2(AW + 1);

    logic [2:0]       bo_reg;
    logic [7:0]       partial_reg;
    logic [2:0]       rbp_reg;
    logic             gen_valid_reg;
    logic [CNT_W-1:0] gen_j_reg;
    logic [CNT_W-1:0] gen_d_reg;
    logic [CNT_W-1:0] gen_n_reg;
    logic [CNT_W-1:0] gen_total_reg;
    logic             gen_img_reg;
    logic [7:0]       gen_bytes_reg [NBY];

    logic [5:0]       t_sum;
    logic [2:0]       nfull;
    logic [2:0]       rem;
    logic [AW-1:0]    aligned;
    logic [AW-1:0]    acc;
    logic [7:0]       acc_bytes [NBY];
    logic             end_any;
    logic             flush;
    logic [CNT_W-1:0] d_cnt;
    logic [2:0]       psum;
    logic [2:0]       pad;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] total;
    logic             last_step;
    logic             gen_free;

    // old partial bits first, then the pixel msb first
    assign t_sum   = {3'b000, bo_reg} + cfg.pw;
    assign nfull   = t_sum[5:3];
    assign rem     = t_sum[2:0];
    assign aligned = {{(AW - MAX_PIXEL_BITS){1'b0}}, pix} << (SH_W'(AW) - SH_W'(cfg.pw));
    assign acc     = (aligned >> bo_reg) | {partial_reg, {(AW - 8){1'b0}}};

    always_comb
    begin
        for (int i = 0; i < NBY; i++) begin
            acc_bytes[i] = acc[AW - 1 - 8 * i -: 8];
        end
    end

    assign end_any = pix_flags.row_end || pix_flags.img;
    assign flush   = end_any && (rem != 3'd0);
    assign d_cnt   = CNT_W'(nfull) + CNT_W'(flush);
    assign psum    = rbp_reg + d_cnt[2:0];
    assign pad     = (pix_flags.row_end && !pix_flags.img) ? ((3'd0 - psum) & cfg.align) : 3'd0;
    assign n_cnt   = d_cnt + CNT_W'(pad);
    assign total   = n_cnt + CNT_W'(pix_flags.img);

    assign last_step   = gen_j_reg == (gen_total_reg - CNT_W'(1));
    assign step_valid  = gen_valid_reg;
    assign step.flush  = gen_img_reg && (gen_j_reg == gen_n_reg);
    assign step.data   = (gen_j_reg < gen_d_reg) ? gen_bytes_reg[gen_j_reg[IDX_W-1:0]] : 8'h00;
    assign step.remain = gen_n_reg - gen_j_reg - CNT_W'(1);
    assign step.img    = gen_img_reg;

    assign gen_free = !gen_valid_reg || (step_ready && last_step);
    assign pix_take = pix_valid && gen_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bo_reg        <= 3'd0;
            partial_reg   <= 8'h00;
            rbp_reg       <= 3'd0;
            gen_valid_reg <= 1'b0;
            gen_j_reg     <= '0;
            gen_d_reg     <= '0;
            gen_n_reg     <= '0;
            gen_total_reg <= '0;
            gen_img_reg   <= 1'b0;
        end
        else if (pix_take)
        begin
            bo_reg        <= end_any ? 3'd0 : rem;
            partial_reg   <= end_any ? 8'h00 : acc_bytes[nfull[IDX_W-1:0]];
            rbp_reg       <= end_any ? 3'd0 : psum;
            gen_valid_reg <= total != '0;
            gen_j_reg     <= '0;
            gen_d_reg     <= d_cnt;
            gen_n_reg     <= n_cnt;
            gen_total_reg <= total;
            gen_img_reg   <= pix_flags.img;
        end
        else if (gen_valid_reg && step_ready)
        begin
            if (last_step)
            begin
                gen_valid_reg <= 1'b0;
            end
            else
            begin
                gen_j_reg <= gen_j_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            gen_bytes_reg <= acc_bytes;
        end
    end

endmodule

FILE: rtl/core/tpp_swap.sv
module tpp_swap
    import tpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step_valid,
    input  step_t      step,
    output logic       step_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic [1:0] phase_reg;
    logic [7:0] hold_reg [3];
    logic [7:0] drain_reg [3];
    logic [1:0] drain_cnt_reg;
    logic       drain_last_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    logic [2:0] grp;
    logic       mirror;
    logic [7:0] b;
    logic       complete;
    logic       is_last;
    logic       out_free;
    logic       drain_empty;
    logic       pop;
    logic       take;
    logic       group_out;
    logic       load_drain;
    logic [7:0] rev [3];

    always_comb
    begin
        grp = 3'd1;
        if (cfg.swap)
        begin
            if (cfg.pw == 6'd32)
            begin
                grp = 3'd4;
            end
            else if (cfg.pw == 6'd24)
            begin
                grp = 3'd3;
            end
            else if (cfg.pw == 6'd16)
            begin
                grp = 3'd2;
            end
        end
    end

    assign mirror   = cfg.swap && (cfg.pw == 6'd1);
    assign b        = mirror ? mirror8(step.data) : step.data;
    assign complete = ({1'b0, phase_reg} + 3'd1) >= grp;
    // no later group closes inside this pixel and no held bytes follow at image end
    assign is_last  = (step.remain < CNT_W'(grp)) && !(step.img && (step.remain != '0));

    assign out_free    = !out_valid_reg || m_tready;
    assign drain_empty = drain_cnt_reg == 2'd0;
    assign pop         = !drain_empty && out_free;

    always_comb
    begin
        if (step.flush)
        begin
            step_ready = drain_empty;
        end
        else if (complete)
        begin
            step_ready = drain_empty && out_free;
        end
        else
        begin
            step_ready = 1'b1;
        end
    end

    assign take       = step_valid && step_ready;
    assign group_out  = take && !step.flush && complete;
    assign load_drain = take && (step.flush || complete);

    // held bytes in reverse order for a closing group
    always_comb
    begin
        rev = hold_reg;
        case (phase_reg)
            2'd1:
            begin
                rev[0] = hold_reg[0];
            end
            2'd2:
            begin
                rev[0] = hold_reg[1];
                rev[1] = hold_reg[0];
            end
            2'd3:
            begin
                rev[0] = hold_reg[2];
                rev[1] = hold_reg[1];
                rev[2] = hold_reg[0];
            end
            default:
            begin
                rev = hold_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 2'd0;
            drain_cnt_reg  <= 2'd0;
            drain_last_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= (step.flush || complete) ? 2'd0 : phase_reg + 2'd1;
            end
            if (load_drain)
            begin
                drain_cnt_reg  <= phase_reg;
                drain_last_reg <= step.flush ? 1'b1 : is_last;
            end
            else if (pop)
            begin
                drain_cnt_reg <= drain_cnt_reg - 2'd1;
            end
            if (out_free)
            begin
                out_valid_reg <= pop || group_out;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !step.flush && !complete)
        begin
            hold_reg[phase_reg] <= b;
        end
        if (load_drain)
        begin
            drain_reg <= step.flush ? hold_reg : rev;
        end
        else if (pop)
        begin
            drain_reg[0] <= drain_reg[1];
            drain_reg[1] <= drain_reg[2];
        end
        if (out_free)
        begin
            if (pop)
            begin
                out_data_reg <= drain_reg[0];
                out_last_reg <= drain_last_reg && (drain_cnt_reg == 2'd1);
            end
            else
            begin
                out_data_reg <= b;
                out_last_reg <= is_last && (phase_reg == 2'd0);
            end
        end
    end

endmodule

FILE: rtl/core/truecolor_pixel_packer_top.sv
// a pixel's first output byte passes through the place register, the pack step registers and
//   the output register; bytes held for swap wait until their group closes
// throughput: one output byte per cycle while m_tready is high; a pixel gives one step per
//   byte it produces (4 at 32 bpp); image end adds a flush step; a closed group drains up to 3
//   held bytes; the byte-wide output register and the byte step counter set that rate
// reset: rst_n clears all control state and loads the default register values
module truecolor_pixel_packer_top
    import tpp_pkg::*;
#(
    parameter int CHANNEL_BITS   = CHANNEL_BITS_DEF,
    parameter int MAX_PIXEL_BITS = MAX_PIXEL_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // red, green, blue from the lowest bit up, zero filled to bytes
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    // image_end
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_byte
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [31:0]                         cfg_data
);

    cfg_t                      cfg;
    pflag_t                    in_flags;
    logic                      pix_valid;
    logic [MAX_PIXEL_BITS-1:0] pix;
    pflag_t                    pix_flags;
    logic                      pix_take;
    logic                      step_valid;
    step_t                     step;
    logic                      step_ready;

    assign in_flags.row_end = s_tlast;
    assign in_flags.img     = s_tuser;

    tpp_cfg #(
        .MAX_PIXEL_BITS (MAX_PIXEL_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpp_place #(
        .CHANNEL_BITS   (CHANNEL_BITS),
        .MAX_PIXEL_BITS (MAX_PIXEL_BITS)
    ) u_place (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[CHANNEL_BITS-1:0]),
        .green     (s_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
        .blue      (s_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
        .in_flags  (in_flags),
        .pix_valid (pix_valid),
        .pix       (pix),
        .pix_flags (pix_flags),
        .pix_take  (pix_take)
    );

    tpp_pack #(
        .MAX_PIXEL_BITS (MAX_PIXEL_BITS)
    ) u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pix_valid  (pix_valid),
        .pix        (pix),
        .pix_flags  (pix_flags),
        .pix_take   (pix_take),
        .step_valid (step_valid),
        .step       (step),
        .step_ready (step_ready)
    );

    tpp_swap u_swap (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step_valid (step_valid),
        .step       (step),
        .step_ready (step_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
